// ----- rtl/core/ffcba_pkg.sv -----
// Shared types and constants for the first-fit contiguous block allocator.
`timescale 1ns / 1ps

package ffcba_pkg;

    // Default number of blocks in the store.
    localparam int NUM_BLOCKS_DEF = 128;

    // Widths of the item fields.
    localparam int KIND_W  = 1;
    localparam int START_W = 7;
    localparam int LEN_W   = 8;
    localparam int STAT_W  = 2;

    // Operation codes carried in the kind field.
    localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 1'b1;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_NOFIT = 2'd1,
        ST_RANGE = 2'd2
    } ffcba_status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic          load;      // latch a new request
        logic          clear_wr;  // write a zero during the clearing pass
        logic          scan;      // one step of the first-fit scan
        logic          fill_wr;   // write one block of a mark or free range
        logic          finish;    // publish a result item
        ffcba_status_t code;      // status of that result
    } ffcba_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;  // the clearing pass is at its last block
        logic bad_range;   // latched request has a zero length or leaves the store
        logic alloc_op;    // latched request is an allocate
        logic found;       // the scan has just completed a fitting run
        logic scan_end;    // the scan has looked at the last block without a fit
        logic fill_last;   // the range write is at its last block
    } ffcba_stat_t;

endpackage

// ----- rtl/core/ffcba_dp.sv -----
// Datapath of the block allocator: bitmap memory, scan and range write counters, result.
`timescale 1ns / 1ps

module ffcba_dp #(
    parameter int NUM_BLOCKS = ffcba_pkg::NUM_BLOCKS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ffcba_pkg::ffcba_cmd_t           cmd,
    output ffcba_pkg::ffcba_stat_t          stat,
    input  logic [ffcba_pkg::KIND_W-1:0]    kind,
    input  logic [ffcba_pkg::START_W-1:0]   start_block,
    input  logic [ffcba_pkg::LEN_W-1:0]     run_length,
    output logic                            done,
    output logic                            granted,
    output logic [ffcba_pkg::START_W-1:0]   run_start,
    output logic [ffcba_pkg::STAT_W-1:0]    status
);

    localparam int IW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CW = $clog2(NUM_BLOCKS + 1);
    localparam int EW = (CW > ffcba_pkg::LEN_W + 1) ? CW : ffcba_pkg::LEN_W + 1;

    logic                            bmap_mem [NUM_BLOCKS];

    logic [ffcba_pkg::KIND_W-1:0]    req_kind_reg;
    logic [ffcba_pkg::START_W-1:0]   req_start_reg;
    logic [ffcba_pkg::LEN_W-1:0]     req_len_reg;
    logic [CW-1:0]                   ptr_reg;
    logic [CW-1:0]                   rem_reg;
    logic [CW-1:0]                   run_cnt_reg;
    logic [IW-1:0]                   proc_idx_reg;
    logic                            proc_valid_reg;
    logic                            map_rd_reg;
    logic [IW-1:0]                   first_reg;
    logic                            done_reg;
    logic                            granted_reg;
    logic [ffcba_pkg::START_W-1:0]   run_start_reg;
    ffcba_pkg::ffcba_status_t        status_reg;

    logic [IW-1:0]                   ptr_idx;
    logic                            issue;
    logic [CW-1:0]                   cnt_inc;
    logic [EW-1:0]                   len_ext;
    logic [EW-1:0]                   first_ext;
    logic                            found;

    assign ptr_idx   = ptr_reg[IW-1:0];
    assign issue     = cmd.scan && (ptr_reg != CW'(NUM_BLOCKS));
    assign cnt_inc   = run_cnt_reg + CW'(1);
    assign len_ext   = EW'(req_len_reg);
    assign first_ext = EW'(proc_idx_reg) + EW'(1) - len_ext;
    assign found     = proc_valid_reg && !map_rd_reg && (cnt_inc == CW'(req_len_reg));

    always_comb
    begin
        stat.clear_last = (ptr_reg == CW'(NUM_BLOCKS - 1));
        stat.alloc_op   = (req_kind_reg == ffcba_pkg::KIND_ALLOC);
        stat.bad_range  = (req_len_reg == '0) ||
                          (stat.alloc_op ? (len_ext > EW'(NUM_BLOCKS))
                                         : (EW'(req_start_reg) + len_ext > EW'(NUM_BLOCKS)));
        stat.found      = found;
        stat.scan_end   = proc_valid_reg && !found && (proc_idx_reg == IW'(NUM_BLOCKS - 1));
        stat.fill_last  = (rem_reg == CW'(1));
    end

    // Bitmap store: one write or one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.clear_wr)
        begin
            bmap_mem[ptr_idx] <= 1'b0;
        end
        else if (cmd.fill_wr)
        begin
            bmap_mem[ptr_idx] <= (req_kind_reg == ffcba_pkg::KIND_ALLOC);
        end
        if (issue)
        begin
            map_rd_reg <= bmap_mem[ptr_idx];
        end
    end

    // Request and result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_kind_reg  <= kind;
            req_start_reg <= start_block;
            req_len_reg   <= run_length;
        end
        if (cmd.scan && found)
        begin
            first_reg <= IW'(first_ext);
        end
        if (cmd.finish)
        begin
            granted_reg   <= (cmd.code == ffcba_pkg::ST_OK);
            status_reg    <= cmd.code;
            run_start_reg <= ((cmd.code == ffcba_pkg::ST_OK) &&
                              (req_kind_reg == ffcba_pkg::KIND_ALLOC))
                             ? ffcba_pkg::START_W'(first_reg) : '0;
        end
    end

    // Counters and control flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg        <= '0;
            rem_reg        <= '0;
            run_cnt_reg    <= '0;
            proc_idx_reg   <= '0;
            proc_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cmd.load)
            begin
                ptr_reg        <= (kind == ffcba_pkg::KIND_ALLOC) ? '0 : CW'(start_block);
                rem_reg        <= CW'(run_length);
                run_cnt_reg    <= '0;
                proc_valid_reg <= 1'b0;
            end
            else if (cmd.clear_wr || cmd.fill_wr)
            begin
                ptr_reg <= ptr_reg + CW'(1);
                rem_reg <= rem_reg - CW'(1);
            end
            else if (cmd.scan)
            begin
                if (found)
                begin
                    ptr_reg        <= CW'(first_ext);
                    rem_reg        <= CW'(req_len_reg);
                    proc_valid_reg <= 1'b0;
                end
                else
                begin
                    if (issue)
                    begin
                        ptr_reg <= ptr_reg + CW'(1);
                    end
                    proc_valid_reg <= issue;
                    proc_idx_reg   <= ptr_idx;
                    if (proc_valid_reg)
                    begin
                        run_cnt_reg <= map_rd_reg ? '0 : cnt_inc;
                    end
                end
            end
        end
    end

    assign done      = done_reg;
    assign granted   = granted_reg;
    assign run_start = run_start_reg;
    assign status    = status_reg;

    // A result strobe lasts a single cycle.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for more than one cycle");

    // Success and the ok status always go together.
    a_grant_status: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (granted_reg == (status_reg == ffcba_pkg::ST_OK)))
        else $error("granted disagrees with status");

    // A failed request reports start block zero.
    a_fail_start: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !granted_reg) |-> (run_start_reg == '0))
        else $error("failed request reports a start block");

    // Range writes never step outside the store.
    a_fill_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fill_wr |-> (ptr_reg < CW'(NUM_BLOCKS)) && (rem_reg != '0))
        else $error("range write outside the store");

endmodule

// ----- rtl/core/ffcba_ctrl.sv -----
// Controller state machine of the block allocator.
`timescale 1ns / 1ps

module ffcba_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    output ffcba_pkg::ffcba_cmd_t  cmd,
    input  ffcba_pkg::ffcba_stat_t stat
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_FILL
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.code   = ffcba_pkg::ST_OK;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.bad_range)
                begin
                    cmd.finish = 1'b1;
                    cmd.code   = ffcba_pkg::ST_RANGE;
                    state_next = S_IDLE;
                end
                else if (stat.alloc_op)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_FILL;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.found)
                begin
                    state_next = S_FILL;
                end
                else if (stat.scan_end)
                begin
                    cmd.finish = 1'b1;
                    cmd.code   = ffcba_pkg::ST_NOFIT;
                    state_next = S_IDLE;
                end
            end
            S_FILL:
            begin
                cmd.fill_wr = 1'b1;
                if (stat.fill_last)
                begin
                    cmd.finish = 1'b1;
                    cmd.code   = ffcba_pkg::ST_OK;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    // A result is only ever published from a working state.
    a_finish_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> busy)
        else $error("result published while idle");

    // The clearing pass is finished before any request is taken.
    a_no_load_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !cmd.load)
        else $error("request taken during the clearing pass");

    // Only one memory operation is commanded in a cycle.
    a_one_mem_op: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clear_wr, cmd.scan, cmd.fill_wr}))
        else $error("conflicting memory commands");

endmodule

// ----- rtl/core/first_fit_contiguous_block_allocator_top.sv -----
// Top level of the first-fit contiguous block allocator.
`timescale 1ns / 1ps
//
//  Channel   Signals                                  Handshake
//  --------  ---------------------------------------  ----------------------------------
//  request   kind, start_block, run_length            taken when start high, busy low
//  result    granted, run_start, status               valid for one cycle while done high
//
// The store is a map of NUM_BLOCKS blocks, one bit each, held in a single-port
// memory that is read or written once per cycle. After reset a clearing pass
// writes every entry to free, with busy high.
// A request with a zero length or a range outside the store returns its item
// from the check state, without a memory access. A free makes one memory
// write per block. An allocate scans the map one block per cycle from block 0
// to find or reject a run, then marks a run it has found with one memory write
// per block.
// Exactly one result item follows each request item; the receiver cannot stall
// it, and busy stays high until the item has been produced.
module first_fit_contiguous_block_allocator_top #(
    parameter int NUM_BLOCKS = ffcba_pkg::NUM_BLOCKS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [ffcba_pkg::KIND_W-1:0]    kind,
    input  logic [ffcba_pkg::START_W-1:0]   start_block,
    input  logic [ffcba_pkg::LEN_W-1:0]     run_length,
    output logic                            done,
    output logic                            granted,
    output logic [ffcba_pkg::START_W-1:0]   run_start,
    output logic [ffcba_pkg::STAT_W-1:0]    status
);

    // Commands and status between the controller and the datapath.
    ffcba_pkg::ffcba_cmd_t  cmd;
    ffcba_pkg::ffcba_stat_t stat;

    // The controller sequences clearing, range checks, scanning and range writes.
    ffcba_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    // The datapath holds the map, the scan counters and the result registers.
    ffcba_dp #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .kind        (kind),
        .start_block (start_block),
        .run_length  (run_length),
        .done        (done),
        .granted     (granted),
        .run_start   (run_start),
        .status      (status)
    );

endmodule
